FILE: rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Payload field widths
    localparam int CMD_W       = 2;
    localparam int CODE_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int ROW_SEL_W   = 5;
    localparam int COL_SEL_W   = 8;
    localparam int CURSOR_W    = 11;
    localparam int CELL_W      = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0700;
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

    // Controller to datapath
    typedef struct packed {
        logic load_item;    // capture the input transaction
        logic exec;         // run the command on the captured item
        logic sweep_step;   // issue one cell of a copy/blank sweep
        logic load_result;  // load the output register
    } tcw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] item_cmd;
        logic             scroll_now;
        logic             sweep_last;
        logic             out_free;
    } tcw_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcw_datapath.sv
// Datapath of the text console writer: cell store, cursor, sweep unit, result register.
// Depends on tcw_pkg; driven by tcw_controller through tcw_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire  tcw_pkg::tcw_cmd_t            cmd,
    output tcw_pkg::tcw_status_t               status,
    input  wire  [tcw_pkg::CMD_W-1:0]          s_command,
    input  wire  [tcw_pkg::CODE_W-1:0]         s_char_code,
    input  wire  [tcw_pkg::ATTR_W-1:0]         s_attribute,
    input  wire  [tcw_pkg::ROW_SEL_W-1:0]      s_row_sel,
    input  wire  [tcw_pkg::COL_SEL_W-1:0]      s_col_sel,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [tcw_pkg::CURSOR_W-1:0]       m_cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]         m_cell_value,
    output logic                               m_scrolled,
    output logic                               m_addr_error
);
    import tcw_pkg::*;

    localparam int CELLS     = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int MEM_AW    = $clog2(CELLS);
    localparam int COL_W     = $clog2(SCREEN_WIDTH);
    localparam int ROW_W     = $clog2(SCREEN_HEIGHT);
    localparam int ADDR_SPAN = (2**ROW_SEL_W - 1) * SCREEN_WIDTH + 2**COL_SEL_W;
    localparam int SPAN_W    = $clog2(ADDR_SPAN);
    localparam int AW        = (SPAN_W > MEM_AW + 1) ? SPAN_W : MEM_AW + 1;

    localparam logic [MEM_AW-1:0] COPY_END  = MEM_AW'((SCREEN_HEIGHT - 1) * SCREEN_WIDTH - 1);
    localparam logic [MEM_AW-1:0] CLEAR_END = MEM_AW'(CELLS - 1);
    localparam logic [MEM_AW-1:0] KEEP_END  = MEM_AW'((SCREEN_HEIGHT - 2) * SCREEN_WIDTH);
    localparam logic [MEM_AW-1:0] WIDTH_A   = MEM_AW'(SCREEN_WIDTH);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [ROW_W-1:0]  SCROLL_ROW = ROW_W'(SCREEN_HEIGHT - 2);

    logic [CELL_W-1:0] mem [CELLS];

    // Captured item
    logic [CMD_W-1:0]  item_cmd_reg;
    logic [CODE_W-1:0] item_code_reg;
    logic [ATTR_W-1:0] item_attr_reg;
    logic [AW-1:0]     item_addr_reg;

    // Cursor
    logic [MEM_AW-1:0] cur_lin_reg, cur_lin_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;

    // Sweep unit
    logic [MEM_AW-1:0] cnt_reg;
    logic              copy_mode_reg;
    logic              stage_valid_reg;
    logic              stage_blank_reg;
    logic [MEM_AW-1:0] stage_addr_reg;
    logic              issue_blank;

    // Flags of the current item
    logic scrolled_reg, scrolled_next;
    logic err_reg, err_next;

    // Memory ports
    logic              mem_we;
    logic [MEM_AW-1:0] mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic [MEM_AW-1:0] mem_ra;
    logic [CELL_W-1:0] rd_q_reg;

    // Output register
    logic                m_valid_reg;
    logic [CURSOR_W-1:0] m_cursor_reg;
    logic [CELL_W-1:0]   m_cell_reg;
    logic                m_scrolled_reg;
    logic                m_err_reg;

    logic is_put, newline, addr_bad;
    logic [MEM_AW-1:0] put_lin;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic              scroll_now;

    assign is_put   = (item_cmd_reg == CMD_PUT);
    assign newline  = (item_code_reg == NEWLINE_CODE);
    assign addr_bad = (item_addr_reg >= AW'(CELLS));

    // Cursor after a put, before any scroll
    always_comb begin
        if (newline) begin
            put_lin = cur_lin_reg - MEM_AW'(cur_col_reg) + WIDTH_A;
            put_col = '0;
            put_row = cur_row_reg + 1'b1;
        end else if (cur_col_reg == LAST_COL) begin
            put_lin = cur_lin_reg + 1'b1;
            put_col = '0;
            put_row = cur_row_reg + 1'b1;
        end else begin
            put_lin = cur_lin_reg + 1'b1;
            put_col = cur_col_reg + 1'b1;
            put_row = cur_row_reg;
        end
    end

    assign scroll_now = is_put && (put_row == LAST_ROW);

    always_comb begin
        cur_lin_next  = cur_lin_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        scrolled_next = scrolled_reg;
        err_next      = err_reg;
        if (cmd.exec) begin
            scrolled_next = 1'b0;
            err_next      = 1'b0;
            case (item_cmd_reg)
                CMD_PUT: begin
                    if (scroll_now) begin
                        cur_lin_next  = KEEP_END;
                        cur_col_next  = '0;
                        cur_row_next  = SCROLL_ROW;
                        scrolled_next = 1'b1;
                    end else begin
                        cur_lin_next = put_lin;
                        cur_col_next = put_col;
                        cur_row_next = put_row;
                    end
                end
                CMD_CLEAR: begin
                    cur_lin_next = '0;
                    cur_col_next = '0;
                    cur_row_next = '0;
                end
                CMD_WRITE, CMD_READ: begin
                    err_next = addr_bad;
                end
                default: begin
                    err_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_lin_reg  <= '0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            scrolled_reg <= 1'b0;
            err_reg      <= 1'b0;
        end else begin
            cur_lin_reg  <= cur_lin_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            scrolled_reg <= scrolled_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_cmd_reg  <= s_command;
            item_code_reg <= s_char_code;
            item_attr_reg <= s_attribute;
            item_addr_reg <= AW'(s_row_sel) * AW'(SCREEN_WIDTH) + AW'(s_col_sel);
        end
    end

    // Sweep: issue one address per cycle and write it back through the staging registers
    assign issue_blank = !copy_mode_reg || (cnt_reg >= KEEP_END);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg         <= '0;
            copy_mode_reg   <= 1'b0;
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= cmd.sweep_step;
            if (cmd.exec) begin
                cnt_reg       <= '0;
                copy_mode_reg <= is_put;
            end else if (cmd.sweep_step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stage_addr_reg  <= cnt_reg;
        stage_blank_reg <= issue_blank;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = stage_addr_reg;
        mem_wd = BLANK_CELL;
        if (stage_valid_reg) begin
            mem_we = 1'b1;
            mem_wd = stage_blank_reg ? BLANK_CELL : rd_q_reg;
        end else if (cmd.exec && is_put && !newline) begin
            mem_we = 1'b1;
            mem_wa = cur_lin_reg;
            mem_wd = {item_attr_reg, item_code_reg};
        end else if (cmd.exec && (item_cmd_reg == CMD_WRITE) && !addr_bad) begin
            mem_we = 1'b1;
            mem_wa = item_addr_reg[MEM_AW-1:0];
            mem_wd = {item_attr_reg, item_code_reg};
        end
    end

    assign mem_ra = (cmd.sweep_step && !issue_blank) ? (cnt_reg + WIDTH_A)
                                                     : item_addr_reg[MEM_AW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        rd_q_reg <= mem[mem_ra];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_cursor_reg   <= CURSOR_W'(cur_lin_next);
            m_cell_reg     <= ((item_cmd_reg == CMD_READ) && !err_next) ? rd_q_reg : '0;
            m_scrolled_reg <= scrolled_next;
            m_err_reg      <= err_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_pos = m_cursor_reg;
    assign m_cell_value = m_cell_reg;
    assign m_scrolled   = m_scrolled_reg;
    assign m_addr_error = m_err_reg;

    assign status.item_cmd   = item_cmd_reg;
    assign status.scroll_now = scroll_now;
    assign status.sweep_last = (cnt_reg == (copy_mode_reg ? COPY_END : CLEAR_END));
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

FILE: rtl/core/tcw_controller.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg; steers tcw_datapath through tcw_cmd_t and reads tcw_status_t.
`timescale 1ns / 1ps
`default_nettype none

module tcw_controller (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t     cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] S_INIT       = 3'd0;
    localparam logic [2:0] S_INIT_DRAIN = 3'd1;
    localparam logic [2:0] S_IDLE       = 3'd2;
    localparam logic [2:0] S_EXEC       = 3'd3;
    localparam logic [2:0] S_SWEEP      = 3'd4;
    localparam logic [2:0] S_DRAIN      = 3'd5;
    localparam logic [2:0] S_RDWAIT     = 3'd6;
    localparam logic [2:0] S_HOLD       = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] finish_state;

    // Deliver the result now if the output register is free, otherwise wait for it
    assign finish_state = status.out_free ? S_IDLE : S_HOLD;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        s_ready         = 1'b0;
        case (state_reg)
            S_INIT: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = S_INIT_DRAIN;
                end
            end
            S_INIT_DRAIN: begin
                state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                case (status.item_cmd)
                    CMD_PUT: begin
                        if (status.scroll_now) begin
                            state_next = S_SWEEP;
                        end else begin
                            cmd.load_result = status.out_free;
                            state_next      = finish_state;
                        end
                    end
                    CMD_CLEAR: begin
                        state_next = S_SWEEP;
                    end
                    CMD_WRITE: begin
                        cmd.load_result = status.out_free;
                        state_next      = finish_state;
                    end
                    CMD_READ: begin
                        state_next = S_RDWAIT;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN, S_RDWAIT, S_HOLD: begin
                cmd.load_result = status.out_free;
                state_next      = finish_state;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/text_console_writer.sv
// Text console writer: put and write-at load their result in the execute state, read-at after a wait
// state for the registered store read; a busy output register holds any of them in a hold state.
// Clear and a scrolling put first run a sweep over the cell store, one cell per cycle, then a drain state.
// One item in flight; the next is accepted while the previous result waits in the output register.
// After reset (synchronous, active low) the store is blanked by a sweep over every cell
// with s_ready low; the cursor starts at the top left cell.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [tcw_pkg::CMD_W-1:0]          s_command,
    input  wire  [tcw_pkg::CODE_W-1:0]         s_char_code,
    input  wire  [tcw_pkg::ATTR_W-1:0]         s_attribute,
    input  wire  [tcw_pkg::ROW_SEL_W-1:0]      s_row_sel,
    input  wire  [tcw_pkg::COL_SEL_W-1:0]      s_col_sel,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [tcw_pkg::CURSOR_W-1:0]       m_cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]         m_cell_value,
    output logic                               m_scrolled,
    output logic                               m_addr_error
);
    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;

    tcw_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcw_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_command    (s_command),
        .s_char_code  (s_char_code),
        .s_attribute  (s_attribute),
        .s_row_sel    (s_row_sel),
        .s_col_sel    (s_col_sel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_pos (m_cursor_pos),
        .m_cell_value (m_cell_value),
        .m_scrolled   (m_scrolled),
        .m_addr_error (m_addr_error)
    );

endmodule

`default_nettype wire

FILE: rtl/core/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_valid,
    input wire                                s_ready,
    input wire [tcw_pkg::CMD_W-1:0]           s_command,
    input wire [tcw_pkg::CODE_W-1:0]          s_char_code,
    input wire [tcw_pkg::ATTR_W-1:0]          s_attribute,
    input wire [tcw_pkg::ROW_SEL_W-1:0]       s_row_sel,
    input wire [tcw_pkg::COL_SEL_W-1:0]       s_col_sel,
    input wire                                m_valid,
    input wire                                m_ready,
    input wire [tcw_pkg::CURSOR_W-1:0]        m_cursor_pos,
    input wire [tcw_pkg::CELL_W-1:0]          m_cell_value,
    input wire                                m_scrolled,
    input wire                                m_addr_error
);
    import tcw_pkg::*;

    localparam logic [CURSOR_W-1:0] SCROLL_POS =
        CURSOR_W'((SCREEN_HEIGHT - 2) * SCREEN_WIDTH);

    logic unused_inputs;
    assign unused_inputs = ^{s_command, s_char_code, s_attribute, s_row_sel, s_col_sel};

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_pos) && $stable(m_cell_value)
                                && $stable(m_scrolled) && $stable(m_addr_error))
        else $error("result changed while stalled");

    // One item at a time: no acceptance in the cycle after an acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    // A scroll always leaves the cursor at the start of the second to last row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scrolled |-> m_cursor_pos == SCROLL_POS)
        else $error("cursor not at scroll row after scroll");

    // A rejected address returns no data and never scrolls
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_addr_error |-> m_cell_value == '0 && !m_scrolled)
        else $error("address error with data or scroll");

endmodule

bind text_console_writer tcw_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tcw_checker (.*);

`default_nettype wire
